@@ rtl/deq_pkg.sv @@
// Shared types, sizes and helper functions of the double-ended queue.
package deq_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int VALUE_W    = 32;
    localparam int ACTION_W   = 2;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [CNT_W-1:0]      count_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OP_HOLD       = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        data_t    value;
    } cell_ctrl_t;

    function automatic value_t data_to_value(data_t d);
        logic [63:0] w;
        w = 64'(d);
        return w[VALUE_W-1:0];
    endfunction

    function automatic data_t value_to_data(value_t v);
        logic [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/deq_cell.sv @@
// One storage cell of the queue chain, holding a single entry and its occupancy bit.
module deq_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::cell_ctrl_t ctrl,
    input  deq_pkg::data_t     left_data,
    input  logic               left_valid,
    input  deq_pkg::data_t     right_data,
    input  logic               right_valid,
    output deq_pkg::data_t     data,
    output logic               valid,
    output logic               is_last
);
    import deq_pkg::*;

    data_t data_reg;
    data_t data_next;
    logic  valid_reg;
    logic  valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (ctrl.op)
            OP_PUSH_FRONT:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            OP_PUSH_BACK:
            begin
                // The first free cell behind an occupied one takes the value.
                if (!valid_reg && left_valid)
                begin
                    data_next  = ctrl.value;
                    valid_next = 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            OP_POP_BACK:
            begin
                if (valid_reg && !right_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign valid   = valid_reg;
    assign is_last = valid_reg && !right_valid;

endmodule

@@ rtl/double_ended_queue_unit.sv @@
// Top level of the double-ended queue: a chain of storage cells with a registered result stage.
//
// Usage: each transfer on the item channel (item_valid, item_stall, action, push_value)
// carries one action: push at the back, push at the front, pop from the front or pop
// from the back. Every item gives exactly one transfer on the result channel
// (result_valid, result_stall) with the popped value, the underflow and overflow flags,
// the fill count after the item and an empty flag.
// The result is registered and presented on result_valid. One item is taken per cycle
// while no waiting result is stalled: all cells shift or hold together, so the row of
// cells sets the rate of one item each cycle, independent of the fill level.
// A pop on an empty queue returns zero with underflow set; a push on a full queue is
// dropped with overflow set. In both cases the contents stay as they were.
// Reset empties the queue and clears the result stage; no item is lost or invented.
// While the receiver stalls a waiting result, item_stall is raised and the result
// register holds its contents until the transfer completes.
module double_ended_queue_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [deq_pkg::ACTION_W-1:0]        action,
    input  logic [deq_pkg::VALUE_W-1:0]         push_value,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [deq_pkg::VALUE_W-1:0]         popped_value,
    output logic                                underflow,
    output logic                                overflow,
    output logic [deq_pkg::CNT_W-1:0]           fill_count,
    output logic                                is_empty
);
    import deq_pkg::*;

    data_t                 link_data [CAPACITY+2];
    logic [CAPACITY+1:0]   link_valid;
    logic [CAPACITY-1:0]   cell_last;
    cell_ctrl_t            ctrl;
    data_t                 back_data;
    data_t                 push_data;
    logic                  item_accept;
    logic                  full;
    logic                  empty;
    action_t               act;

    count_t                count_reg;
    count_t                count_next;
    logic                  result_valid_reg;
    logic                  result_valid_next;
    value_t                popped_reg;
    value_t                popped_next;
    logic                  underflow_reg;
    logic                  underflow_next;
    logic                  overflow_reg;
    logic                  overflow_next;
    count_t                fill_reg;
    logic                  empty_reg;

    assign item_stall  = result_valid_reg && result_stall;
    assign item_accept = item_valid && !item_stall;
    assign act         = action_t'(action);
    assign push_data   = value_to_data(push_value);
    assign full        = link_valid[CAPACITY];
    assign empty       = !link_valid[1];

    // The push value enters from the front end of the chain; the far end reads as empty.
    assign link_data[0]           = push_data;
    assign link_valid[0]          = 1'b1;
    assign link_data[CAPACITY+1]  = '0;
    assign link_valid[CAPACITY+1] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        deq_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_data   (link_data[i]),
            .left_valid  (link_valid[i]),
            .right_data  (link_data[i+2]),
            .right_valid (link_valid[i+2]),
            .data        (link_data[i+1]),
            .valid       (link_valid[i+1]),
            .is_last     (cell_last[i])
        );
    end

    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_last[i])
            begin
                back_data = back_data | link_data[i+1];
            end
        end
    end

    always_comb
    begin
        ctrl.op        = OP_HOLD;
        ctrl.value     = push_data;
        count_next     = count_reg;
        popped_next    = '0;
        underflow_next = 1'b0;
        overflow_next  = 1'b0;
        unique case (act)
            ACT_PUSH_BACK, ACT_PUSH_FRONT:
            begin
                if (full)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    ctrl.op    = (act == ACT_PUSH_BACK) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (empty)
                begin
                    underflow_next = 1'b1;
                end
                else
                begin
                    ctrl.op     = (act == ACT_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
                    popped_next = data_to_value((act == ACT_POP_FRONT) ? link_data[1]
                                                                       : back_data);
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                ctrl.op = OP_HOLD;
            end
        endcase
        if (!item_accept)
        begin
            ctrl.op    = OP_HOLD;
            count_next = count_reg;
        end
    end

    always_comb
    begin
        if (item_accept)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            popped_reg    <= popped_next;
            underflow_reg <= underflow_next;
            overflow_reg  <= overflow_next;
            fill_reg      <= count_next;
            empty_reg     <= (count_next == '0);
        end
    end

    assign result_valid = result_valid_reg;
    assign popped_value = popped_reg;
    assign underflow    = underflow_reg;
    assign overflow     = overflow_reg;
    assign fill_count   = fill_reg;
    assign is_empty     = empty_reg;

`ifndef ASSERT_OFF
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(link_valid[CAPACITY:1]) == int'(count_reg))
        else $error("entry count disagrees with occupied cells");

    a_front_cell_empty: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[1] == (count_reg != '0))
        else $error("front cell occupancy disagrees with entry count");

    a_overflow_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && overflow_next) |=> (count_reg == $past(count_reg)))
        else $error("dropped push changed the entry count");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> ($stable(popped_reg) && $stable(fill_reg)))
        else $error("waiting result changed while stalled");
`endif

endmodule
